@@ hdl/mmbm_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI binding mapper package
// Shared constants, message codes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mmbm_pkg;

    // Default sizes of the binding table and of the per-message result limit.
    localparam int NUM_BINDINGS_DEF = 16;
    localparam int MAX_UPDATES_DEF  = 16;

    // At most this many results leave for one message, and the four-bit slot
    // index field reaches no further than this many slots.
    localparam int RESULT_CAP = 16;

    // Field widths.
    localparam int VALUE_W = 14;
    localparam int BIND_W  = 4;

    // Upper nibbles of the recognised status bytes.
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL_CHG = 4'hB;
    localparam logic [3:0] ST_BEND     = 4'hE;

    // Binding kinds.
    localparam logic [1:0] KIND_CC   = 2'd0;
    localparam logic [1:0] KIND_NOTE = 2'd1;
    localparam logic [1:0] KIND_BEND = 2'd2;

    // Channel code that matches every channel.
    localparam logic [7:0] ANY_CHANNEL = 8'hFF;

    // Full-scale and zero output values.
    localparam logic [VALUE_W-1:0] FULL_SCALE = 14'h3FFF;
    localparam logic [VALUE_W-1:0] ZERO_SCALE = 14'h0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;   // store the binding entry on the input ports
        logic load;    // capture the decoded message
        logic step;    // examine the slot at the scan index
        logic flush;   // release the held result as the final one
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic msg_ok;  // the input word is a recognised message
        logic hit;     // the slot under the scan gives a result
    } t_stat;

endpackage

@@ hdl/mmbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// MIDI binding mapper controller
// Accepts words, sequences the slot scan and ends it on the last slot or when
// the result limit is reached.
// ----------------------------------------------------------------------------
module mmbm_ctrl #(
    parameter int SLOTS = 16,
    parameter int LIMIT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            i_action,
    input  mmbm_pkg::t_stat                 i_stat,
    output logic                            busy,
    output mmbm_pkg::t_cmd                  o_cmd,
    output logic [(SLOTS>1 ? $clog2(SLOTS) : 1)-1:0] o_idx
);
    import mmbm_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(LIMIT + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;
    logic             scan_end;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign scan_end = (r_idx == IDX_W'(SLOTS - 1))
                   || (i_stat.hit && (r_cnt == CNT_W'(LIMIT - 1)));

    // Commands issued in the current cycle.
    always_comb begin
        o_cmd.write = accept && i_action;
        o_cmd.load  = accept && !i_action && i_stat.msg_ok;
        o_cmd.step  = (r_state == S_SCAN);
        o_cmd.flush = (r_state == S_FLUSH);
    end

    assign o_idx = r_idx;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_cnt = '0;
                if (o_cmd.load) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (scan_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ hdl/mmbm_datapath.sv @@
// ----------------------------------------------------------------------------
// MIDI binding mapper datapath
// Holds the binding table and the toggle and input levels, decodes messages,
// matches one slot per step and holds one result back so that the final one
// can be marked.
// ----------------------------------------------------------------------------
module mmbm_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mmbm_pkg::t_cmd                         i_cmd,
    input  logic [(SLOTS>1 ? $clog2(SLOTS) : 1)-1:0] i_idx,
    input  logic [23:0]                            i_midi_word,
    input  logic [3:0]                             i_entry_index,
    input  logic                                   i_entry_valid,
    input  logic [1:0]                             i_entry_kind,
    input  logic [7:0]                             i_entry_channel,
    input  logic [6:0]                             i_entry_control,
    input  logic                                   i_entry_toggle,
    input  logic                                   i_entry_start_high,
    output mmbm_pkg::t_stat                        o_stat,
    output logic                                   o_strobe,
    output logic [mmbm_pkg::BIND_W-1:0]            o_binding_index,
    output logic [mmbm_pkg::VALUE_W-1:0]           o_value,
    output logic                                   o_last
);
    import mmbm_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Binding table; only the valid bits and levels are reset.
    logic             r_vld   [SLOTS];
    logic [1:0]       r_kind  [SLOTS];
    logic [7:0]       r_chan  [SLOTS];
    logic [6:0]       r_ctrl  [SLOTS];
    logic             r_tog   [SLOTS];
    logic             r_tlev  [SLOTS];
    logic             r_ilev  [SLOTS];

    // Captured message.
    logic [1:0]         r_mkind;
    logic [3:0]         r_mchan;
    logic [6:0]         r_mdata1;
    logic [VALUE_W-1:0] r_mvalue;

    // Held result.
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic [VALUE_W-1:0] r_pval;

    // Output register.
    logic               r_ostb;
    logic [BIND_W-1:0]  r_oidx;
    logic [VALUE_W-1:0] r_oval;
    logic               r_olast;

    logic [3:0]         st_hi;
    logic [6:0]         w_d1;
    logic [6:0]         w_d2;
    logic               dec_ok;
    logic [1:0]         dec_kind;
    logic [VALUE_W-1:0] dec_value;

    logic               m_sel;
    logic               m_high;
    logic               m_rise;
    logic               m_hit;
    logic               m_tnew;
    logic [VALUE_W-1:0] m_outv;

    // Message decode from the input word.
    assign st_hi = i_midi_word[7:4];
    assign w_d1  = i_midi_word[14:8];
    assign w_d2  = i_midi_word[22:16];

    always_comb begin
        dec_ok    = 1'b1;
        dec_kind  = KIND_CC;
        dec_value = {w_d2, w_d2};
        case (st_hi)
            ST_CTRL_CHG: begin
                dec_kind  = KIND_CC;
                dec_value = {w_d2, w_d2};
            end
            ST_NOTE_ON: begin
                dec_kind  = KIND_NOTE;
                dec_value = {w_d2, w_d2};
            end
            ST_NOTE_OFF: begin
                dec_kind  = KIND_NOTE;
                dec_value = ZERO_SCALE;
            end
            ST_BEND: begin
                dec_kind  = KIND_BEND;
                dec_value = {w_d2, w_d1};
            end
            default: begin
                dec_ok = 1'b0;
            end
        endcase
    end

    // Match of the slot under the scan against the captured message.
    always_comb begin
        m_sel  = r_vld[i_idx] && (r_kind[i_idx] == r_mkind)
              && ((r_chan[i_idx] == ANY_CHANNEL) || (r_chan[i_idx] == {4'h0, r_mchan}))
              && ((r_mkind == KIND_BEND) || (r_ctrl[i_idx] == r_mdata1));
        m_high = r_mvalue[VALUE_W-1];
        m_rise = m_high && !r_ilev[i_idx];
        m_tnew = !r_tlev[i_idx];
        m_hit  = m_sel && (!r_tog[i_idx] || m_rise);
        m_outv = r_tog[i_idx] ? (m_tnew ? FULL_SCALE : ZERO_SCALE) : r_mvalue;
    end

    always_comb begin
        o_stat.msg_ok = dec_ok;
        o_stat.hit    = i_cmd.step && m_hit;
    end

    // Valid bits and levels: entry writes and toggle updates during the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) begin
                r_vld[j]  <= 1'b0;
                r_tlev[j] <= 1'b0;
                r_ilev[j] <= 1'b0;
            end
        end else begin
            if (i_cmd.write) begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (i_entry_index == 4'(j)) begin
                        r_vld[j]  <= i_entry_valid;
                        r_tlev[j] <= i_entry_start_high;
                        r_ilev[j] <= 1'b0;
                    end
                end
            end
            if (i_cmd.step && m_sel && r_tog[i_idx]) begin
                r_ilev[i_idx] <= m_high;
                if (m_rise) begin
                    r_tlev[i_idx] <= m_tnew;
                end
            end
        end
    end

    // Binding entry payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (i_entry_index == 4'(j)) begin
                    r_kind[j] <= i_entry_kind;
                    r_chan[j] <= i_entry_channel;
                    r_ctrl[j] <= i_entry_control;
                    r_tog[j]  <= i_entry_toggle;
                end
            end
        end
    end

    // Message capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mkind  <= dec_kind;
            r_mchan  <= i_midi_word[3:0];
            r_mdata1 <= w_d1;
            r_mvalue <= dec_value;
        end
    end

    // Held result and output register: a new hit releases the held one as
    // not final, and the flush releases it as the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ostb <= 1'b0;
        end else begin
            r_ostb <= 1'b0;
            if (i_cmd.step && m_hit) begin
                r_pend  <= 1'b1;
                r_pidx  <= i_idx;
                r_pval  <= m_outv;
                r_ostb  <= r_pend;
                r_oidx  <= BIND_W'(r_pidx);
                r_oval  <= r_pval;
                r_olast <= 1'b0;
            end else if (i_cmd.flush) begin
                r_pend  <= 1'b0;
                r_ostb  <= r_pend;
                r_oidx  <= BIND_W'(r_pidx);
                r_oval  <= r_pval;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_strobe        = r_ostb;
    assign o_binding_index = r_oidx;
    assign o_value         = r_oval;
    assign o_last          = r_olast;

endmodule

@@ hdl/midi_message_binding_mapper_top.sv @@
// ----------------------------------------------------------------------------
// MIDI binding mapper, top level
// A binding write keeps busy low. A recognised message holds busy while its
// slots are scanned, one slot a cycle, and through the flush state that
// follows; no new word is accepted until busy falls again.
// A result waits for the next hit and leaves the cycle after it, or for the end
// of the scan and is registered out in the flush state after the last slot
// scanned. The receiver cannot stall.
// A synchronous reset invalidates all slots and clears all levels.
// ----------------------------------------------------------------------------
module midi_message_binding_mapper_top #(
    parameter int NUM_BINDINGS = mmbm_pkg::NUM_BINDINGS_DEF,
    parameter int MAX_UPDATES  = mmbm_pkg::MAX_UPDATES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [23:0]                  i_midi_word,
    input  logic [3:0]                   i_entry_index,
    input  logic                         i_entry_valid,
    input  logic [1:0]                   i_entry_kind,
    input  logic [7:0]                   i_entry_channel,
    input  logic [6:0]                   i_entry_control,
    input  logic                         i_entry_toggle,
    input  logic                         i_entry_start_high,
    output logic                         o_strobe,
    output logic [mmbm_pkg::BIND_W-1:0]  o_binding_index,
    output logic [mmbm_pkg::VALUE_W-1:0] o_value,
    output logic                         o_last
);
    import mmbm_pkg::*;

    // Slots beyond the reach of the index field can never be written.
    localparam int SLOTS = (NUM_BINDINGS < RESULT_CAP) ? NUM_BINDINGS : RESULT_CAP;
    localparam int LIMIT = (MAX_UPDATES < RESULT_CAP) ? MAX_UPDATES : RESULT_CAP;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] scan_idx;

    // Scan sequencer.
    mmbm_ctrl #(
        .SLOTS (SLOTS),
        .LIMIT (LIMIT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .busy     (busy),
        .o_cmd    (cmd),
        .o_idx    (scan_idx)
    );

    // Table, matching and result output.
    mmbm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_idx              (scan_idx),
        .i_midi_word        (i_midi_word),
        .i_entry_index      (i_entry_index),
        .i_entry_valid      (i_entry_valid),
        .i_entry_kind       (i_entry_kind),
        .i_entry_channel    (i_entry_channel),
        .i_entry_control    (i_entry_control),
        .i_entry_toggle     (i_entry_toggle),
        .i_entry_start_high (i_entry_start_high),
        .o_stat             (stat),
        .o_strobe           (o_strobe),
        .o_binding_index    (o_binding_index),
        .o_value            (o_value),
        .o_last             (o_last)
    );

endmodule
